// ===== design/tip_pkg.sv =====
// Shared types, constants and helper functions of the text-to-integer parser.
package tip_pkg;

	localparam logic [2:0] PH_SPACE  = 3'd0;
	localparam logic [2:0] PH_START  = 3'd1;
	localparam logic [2:0] PH_ZERO   = 3'd2;
	localparam logic [2:0] PH_HEXREQ = 3'd3;
	localparam logic [2:0] PH_DIGITS = 3'd4;
	localparam logic [2:0] PH_DONE   = 3'd5;

	localparam logic [5:0] BASE_AUTO = 6'd0;
	localparam logic [5:0] BASE_UNIT = 6'd1;
	localparam logic [5:0] BASE_OCT  = 6'd8;
	localparam logic [5:0] BASE_DEC  = 6'd10;
	localparam logic [5:0] BASE_HEX  = 6'd16;
	localparam logic [5:0] BASE_MAX  = 6'd36;
	localparam logic [5:0] DIGIT_NONE = 6'd36;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_UC_A  = 8'h41;
	localparam logic [7:0] CH_UC_X  = 8'h58;
	localparam logic [7:0] CH_UC_Z  = 8'h5a;
	localparam logic [7:0] CH_LC_A  = 8'h61;
	localparam logic [7:0] CH_LC_X  = 8'h78;
	localparam logic [7:0] CH_LC_Z  = 8'h7a;

	typedef struct packed {
		logic [2:0]  phase;
		logic [63:0] acc;
		logic        neg;
		logic [5:0]  base;
	} tip_state_t;

	typedef struct packed {
		logic advance;
		logic mark_stop;
	} tip_ctl_t;

	function automatic logic [5:0] digit_value(input logic [7:0] c);
		logic [7:0] d;
		begin
			d = 8'(DIGIT_NONE);
			if (c >= CH_ZERO && c <= CH_NINE) begin
				d = c - CH_ZERO;
			end else if (c >= CH_LC_A && c <= CH_LC_Z) begin
				d = c - CH_LC_A + 8'd10;
			end else if (c >= CH_UC_A && c <= CH_UC_Z) begin
				d = c - CH_UC_A + 8'd10;
			end
			return d[5:0];
		end
	endfunction

endpackage

// ===== design/tip_step.sv =====
// Next-state logic of the parser for one non-NUL character.
module tip_step (
	input  logic [7:0]          char_in,
	input  logic [5:0]          base_select,
	input  tip_pkg::tip_state_t cur,
	output tip_pkg::tip_state_t nxt,
	output tip_pkg::tip_ctl_t   ctl
);

	logic [5:0]  digit;
	logic [5:0]  start_base;
	logic [5:0]  digit_base;
	logic        start_bad;
	logic        zero_prefix;
	logic        digit_ok;
	logic        is_space;
	logic        is_sign;
	logic        do_start;
	logic        do_take;
	logic [63:0] product;
	logic [63:0] next_acc;

	assign digit       = tip_pkg::digit_value(char_in);
	assign start_bad   = (base_select == tip_pkg::BASE_UNIT) || (base_select > tip_pkg::BASE_MAX);
	assign zero_prefix = ((base_select == tip_pkg::BASE_AUTO) ||
	                      (base_select == tip_pkg::BASE_HEX)) && (char_in == tip_pkg::CH_ZERO);
	assign start_base  = (base_select == tip_pkg::BASE_AUTO) ? tip_pkg::BASE_DEC : base_select;
	assign digit_base  = ((cur.phase == tip_pkg::PH_SPACE) || (cur.phase == tip_pkg::PH_START))
	                     ? start_base : cur.base;
	assign digit_ok    = digit < digit_base;
	assign is_space    = (char_in == tip_pkg::CH_SPACE) ||
	                     ((char_in >= tip_pkg::CH_TAB) && (char_in <= tip_pkg::CH_CR));
	assign is_sign     = (char_in == tip_pkg::CH_MINUS) || (char_in == tip_pkg::CH_PLUS);
	assign product     = cur.acc * {58'd0, digit_base};
	assign next_acc    = product + {58'd0, digit};

	always_comb begin
		nxt      = cur;
		ctl      = '0;
		do_start = 1'b0;
		do_take  = 1'b0;
		case (cur.phase)
			tip_pkg::PH_SPACE: begin
				if (is_space) begin
					ctl.advance = 1'b1;
				end else if (is_sign) begin
					nxt.neg     = (char_in == tip_pkg::CH_MINUS);
					ctl.advance = 1'b1;
					nxt.phase   = tip_pkg::PH_START;
				end else begin
					do_start = 1'b1;
				end
			end
			tip_pkg::PH_START: begin
				do_start = 1'b1;
			end
			tip_pkg::PH_ZERO: begin
				if ((char_in == tip_pkg::CH_LC_X) || (char_in == tip_pkg::CH_UC_X)) begin
					nxt.base    = tip_pkg::BASE_HEX;
					ctl.advance = 1'b1;
					nxt.phase   = tip_pkg::PH_HEXREQ;
				end else begin
					do_take = 1'b1;
				end
			end
			tip_pkg::PH_HEXREQ, tip_pkg::PH_DIGITS: begin
				do_take = 1'b1;
			end
			default: begin
				nxt.phase = tip_pkg::PH_DONE;
			end
		endcase

		if (do_start) begin
			if (start_bad) begin
				nxt.phase = tip_pkg::PH_DONE;
			end else if (zero_prefix) begin
				nxt.base      = (base_select == tip_pkg::BASE_AUTO) ? tip_pkg::BASE_OCT
				                                                    : tip_pkg::BASE_HEX;
				ctl.advance   = 1'b1;
				ctl.mark_stop = 1'b1;
				nxt.phase     = tip_pkg::PH_ZERO;
			end else begin
				nxt.base = start_base;
				do_take  = 1'b1;
			end
		end

		if (do_take) begin
			if (digit_ok) begin
				nxt.acc       = next_acc;
				ctl.advance   = 1'b1;
				ctl.mark_stop = 1'b1;
				nxt.phase     = tip_pkg::PH_DIGITS;
			end else begin
				nxt.phase = tip_pkg::PH_DONE;
			end
		end
	end

endmodule

// ===== design/text_to_integer_parser_core.sv =====
// Top level of the text-to-integer parser: input register, parse state and result register.
// A character request is first captured in the input register and parsed from there; a NUL
// also loads the result register when it leaves the input register, which raises m_tvalid.
// Throughput is one character per cycle when not stalled, set by the combinational multiply-add by the base.
// The input stalls only while a NUL waits for the result register to be taken.
// Reset clears the parse state, the input and result valid flags, and sets the base to ten.
module text_to_integer_parser_core #(
	parameter int MAX_OFFSET = 4095
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [5:0]  cfg_wr_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] char_in
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata    // [63:0] parsed_value, [75:64] end_offset, [79:76] zero
);

	localparam int POS_W = $clog2(MAX_OFFSET + 1);

	logic [5:0]          base_select_q;
	logic                valid_s1;
	logic [7:0]          char_s1;
	tip_pkg::tip_state_t state_q;
	tip_pkg::tip_state_t state_nxt;
	tip_pkg::tip_ctl_t   ctl;
	logic [POS_W-1:0]    char_pos_q;
	logic [POS_W-1:0]    stop_pos_q;
	logic [POS_W-1:0]    pos_adv;
	logic                out_valid_q;
	logic [63:0]         out_value_q;
	logic [11:0]         out_offset_q;
	logic                out_free;
	logic                is_nul;
	logic                go_s1;
	logic                nul_go;

	tip_step u_step (
		.char_in     (char_s1),
		.base_select (base_select_q),
		.cur         (state_q),
		.nxt         (state_nxt),
		.ctl         (ctl)
	);

	assign out_free = !out_valid_q || m_tready;
	assign is_nul   = (char_s1 == tip_pkg::CH_NUL);
	assign go_s1    = valid_s1 && (!is_nul || out_free);
	assign nul_go   = go_s1 && is_nul;
	assign s_tready = !valid_s1 || go_s1;
	assign pos_adv  = (char_pos_q < POS_W'(MAX_OFFSET)) ? char_pos_q + POS_W'(1) : char_pos_q;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'd0, out_offset_q, out_value_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_select_q <= tip_pkg::BASE_DEC;
		end else if (cfg_wr_en) begin
			base_select_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			char_s1 <= s_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= '{phase: tip_pkg::PH_SPACE, acc: 64'd0, neg: 1'b0, base: 6'd0};
			char_pos_q <= '0;
			stop_pos_q <= '0;
		end else if (nul_go) begin
			state_q    <= '{phase: tip_pkg::PH_SPACE, acc: 64'd0, neg: 1'b0, base: 6'd0};
			char_pos_q <= '0;
			stop_pos_q <= '0;
		end else if (go_s1) begin
			state_q <= state_nxt;
			if (ctl.advance) begin
				char_pos_q <= pos_adv;
			end
			if (ctl.mark_stop) begin
				stop_pos_q <= pos_adv;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (nul_go) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (nul_go) begin
			out_value_q  <= state_q.neg ? (64'd0 - state_q.acc) : state_q.acc;
			out_offset_q <= 12'(stop_pos_q);
		end
	end

`ifndef SYNTH
	// A NUL that finds the result register occupied must hold the input side.
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && is_nul && out_valid_q && !m_tready) |-> !s_tready)
		else $error("NUL passed while the result register was full");

	// After a result is taken into the result register the parse state starts over.
	assert property (@(posedge clk) disable iff (!arst_n)
		nul_go |=> (state_q.phase == tip_pkg::PH_SPACE) && (state_q.acc == 64'd0) &&
		           (char_pos_q == '0) && m_tvalid)
		else $error("Parse state not cleared after end of string");

	// The stop point never lies beyond the consumed character count.
	assert property (@(posedge clk) disable iff (!arst_n)
		(stop_pos_q <= char_pos_q) && (char_pos_q <= POS_W'(MAX_OFFSET)))
		else $error("Position counters out of order");
`endif

endmodule

// ===== verif/tb_text_to_integer_parser_core.sv =====
`timescale 1ns / 100ps
// Testbench for text_to_integer_parser_core: random character streams checked against a predictor.
module tb_text_to_integer_parser_core;
	import tip_pkg::*;

	localparam int MAX_OFFSET = 4095;
	localparam int QUIET_LIMIT = 5000;
	localparam int HOLD_CYCLES = 400;
	localparam int SETTLE_CYCLES = 4;
	localparam int PHASE_CHARS = 78;
	localparam int LONG_SPACES = 40;

	typedef struct packed {
		logic [63:0] value;
		logic [11:0] offset;
	} number_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [5:0] cfg_wr_data = BASE_DEC;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [7:0] s_tdata = CH_NUL;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [79:0] m_tdata;

	logic [7:0] pending_chars[$];
	number_t expected_numbers[$];

	logic [5:0] base_reg = BASE_DEC;
	logic [2:0] num_phase = PH_SPACE;
	logic [63:0] num_acc = '0;
	logic num_neg = 1'b0;
	logic [5:0] num_base = '0;
	logic [11:0] num_pos = '0;
	logic [11:0] num_stop = '0;

	int mismatch_count = 0;
	int chars_queued = 0;
	int chars_accepted = 0;
	int numbers_checked = 0;
	int bases_used = 0;
	int send_wait = 0;
	int sink_wait = 0;
	int hold_left = 0;
	logic hold_go = 1'b0;
	logic calm = 1'b0;

	text_to_integer_parser_core #(
		.MAX_OFFSET(MAX_OFFSET)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) begin
			return 0;
		end else if (r < 85) begin
			return $urandom_range(1, 3);
		end else if (r < 97) begin
			return $urandom_range(4, 10);
		end
		return $urandom_range(20, 40);
	endfunction

	task automatic report_mismatch(input string msg);
		$display("[%0t] MISMATCH: %s", $time, msg);
		mismatch_count++;
	endtask

	task automatic bump_pos();
		if (num_pos < MAX_OFFSET) begin
			num_pos++;
		end
	endtask

	task automatic take_digit(input logic [7:0] c);
		int unsigned d;
		d = DIGIT_NONE;
		if (c >= CH_ZERO && c <= CH_NINE) begin
			d = c - CH_ZERO;
		end else if (c >= CH_LC_A && c <= CH_LC_Z) begin
			d = c - CH_LC_A + 10;
		end else if (c >= CH_UC_A && c <= CH_UC_Z) begin
			d = c - CH_UC_A + 10;
		end
		if (d < num_base) begin
			num_acc = num_acc * 64'(num_base) + 64'(d);
			bump_pos();
			num_stop = num_pos;
			num_phase = PH_DIGITS;
		end else begin
			num_phase = PH_DONE;
		end
	endtask

	// The base register is sampled here, when the number begins.
	task automatic start_number(input logic [7:0] c);
		if (base_reg == BASE_UNIT || base_reg > BASE_MAX) begin
			num_phase = PH_DONE;
		end else if ((base_reg == BASE_AUTO || base_reg == BASE_HEX) && c == CH_ZERO) begin
			num_base = (base_reg == BASE_AUTO) ? BASE_OCT : BASE_HEX;
			bump_pos();
			num_stop = num_pos;
			num_phase = PH_ZERO;
		end else begin
			num_base = (base_reg == BASE_AUTO) ? BASE_DEC : base_reg;
			take_digit(c);
		end
	endtask

	task automatic parse_char(input logic [7:0] c);
		number_t e;
		if (c == CH_NUL) begin
			e.value = num_neg ? 64'd0 - num_acc : num_acc;
			e.offset = num_stop;
			expected_numbers.push_back(e);
			num_phase = PH_SPACE;
			num_acc = '0;
			num_neg = 1'b0;
			num_base = '0;
			num_pos = '0;
			num_stop = '0;
			return;
		end
		case (num_phase)
			PH_SPACE: begin
				if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
					bump_pos();
				end else if (c == CH_MINUS || c == CH_PLUS) begin
					num_neg = (c == CH_MINUS);
					bump_pos();
					num_phase = PH_START;
				end else begin
					start_number(c);
				end
			end
			PH_START: begin
				start_number(c);
			end
			PH_ZERO: begin
				if (c == CH_LC_X || c == CH_UC_X) begin
					num_base = BASE_HEX;
					bump_pos();
					num_phase = PH_HEXREQ;
				end else begin
					take_digit(c);
				end
			end
			PH_HEXREQ, PH_DIGITS: begin
				take_digit(c);
			end
			default: begin
				num_phase = PH_DONE;
			end
		endcase
	endtask

	task automatic check_result(input logic [79:0] data);
		number_t e;
		numbers_checked++;
		if (expected_numbers.size() == 0) begin
			report_mismatch($sformatf("unexpected result value=%0d offset=%0d",
				$signed(data[63:0]), data[75:64]));
			return;
		end
		e = expected_numbers.pop_front();
		if (data[63:0] !== e.value) begin
			report_mismatch($sformatf("parsed_value %0d, expected %0d",
				$signed(data[63:0]), $signed(e.value)));
		end
		if (data[75:64] !== e.offset) begin
			report_mismatch($sformatf("end_offset %0d, expected %0d", data[75:64], e.offset));
		end
		if (data[79:76] !== 4'd0) begin
			report_mismatch($sformatf("padding bits %b, expected zero", data[79:76]));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= CH_NUL;
			send_wait = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				parse_char(s_tdata);
				chars_accepted++;
			end
			if (!s_tvalid || s_tready) begin
				if (send_wait != 0 || pending_chars.size() == 0) begin
					s_tvalid <= 1'b0;
					if (send_wait != 0) begin
						send_wait--;
					end
				end else begin
					s_tvalid <= 1'b1;
					s_tdata <= pending_chars.pop_front();
					if (!calm && $urandom_range(0, 2) == 0) begin
						send_wait = pick_gap();
					end
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			sink_wait = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				check_result(m_tdata);
			end
			if (hold_left != 0 || sink_wait != 0) begin
				m_tready <= 1'b0;
				if (sink_wait != 0) begin
					sink_wait--;
				end
			end else begin
				m_tready <= 1'b1;
				if (!calm && $urandom_range(0, 3) == 0) begin
					sink_wait = pick_gap();
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
		end else if (hold_go) begin
			hold_left <= HOLD_CYCLES;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("timeout: no request moved for %0d cycles", QUIET_LIMIT);
		$display("end of test: mismatches");
		$finish;
	end

	task automatic push_char(input logic [7:0] c);
		pending_chars.push_back(c);
		chars_queued++;
	endtask

	task automatic queue_text(input string s, input bit terminate);
		for (int i = 0; i < s.len(); i++) begin
			push_char(s[i]);
		end
		if (terminate) begin
			push_char(CH_NUL);
		end
	endtask

	function automatic logic [7:0] space_char();
		int r;
		r = $urandom_range(0, 5);
		return (r == 5) ? CH_SPACE : 8'(CH_TAB + r);
	endfunction

	function automatic logic [7:0] digit_char(input int unsigned d);
		if (d < 10) begin
			return 8'(CH_ZERO + d);
		end
		return 8'(($urandom_range(0, 1) ? CH_LC_A : CH_UC_A) + d - 10);
	endfunction

	task automatic queue_number(input logic [5:0] b);
		int unsigned n;
		int unsigned digit_base;
		if ($urandom_range(0, 9) == 0) begin
			repeat ($urandom_range(0, 6)) push_char(8'($urandom_range(1, 255)));
		end else begin
			repeat ($urandom_range(0, 2)) push_char(space_char());
			case ($urandom_range(0, 3))
				0: push_char(CH_MINUS);
				1: push_char(CH_PLUS);
				default: ;
			endcase
			digit_base = (b >= 2 && b <= BASE_MAX) ? b : BASE_MAX;
			if (b == BASE_AUTO || b == BASE_HEX) begin
				case ($urandom_range(0, 3))
					0: begin
						push_char(CH_ZERO);
						push_char($urandom_range(0, 1) ? CH_LC_X : CH_UC_X);
						digit_base = BASE_HEX;
					end
					1: begin
						push_char(CH_ZERO);
						if (b == BASE_AUTO) begin
							digit_base = BASE_OCT;
						end
					end
					default: begin
						if (b == BASE_AUTO) begin
							digit_base = BASE_DEC;
						end
					end
				endcase
			end
			if ($urandom_range(0, 15) == 0) begin
				n = 0;
			end else if ($urandom_range(0, 6) == 0) begin
				n = $urandom_range(9, 30);
			end else begin
				n = $urandom_range(1, 6);
			end
			repeat (n) push_char(digit_char($urandom_range(0, digit_base - 1)));
			if ($urandom_range(0, 2) == 0) begin
				repeat ($urandom_range(1, 3)) push_char(8'($urandom_range(1, 255)));
			end
		end
		push_char(CH_NUL);
	endtask

	task automatic wait_idle();
		do begin
			@(negedge clk);
		end while (pending_chars.size() != 0 || s_tvalid || expected_numbers.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_base(input logic [5:0] b);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= b;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		base_reg = b;
		bases_used++;
		@(negedge clk);
	endtask

	initial begin
		logic [5:0] phase_bases[12];
		logic [5:0] b;
		int phase_end;
		phase_bases = '{BASE_AUTO, BASE_HEX, BASE_DEC, 6'd2, BASE_MAX, BASE_OCT, BASE_UNIT,
			6'd37, 6'd63, 6'd3, BASE_AUTO, BASE_AUTO};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset base is ten: sign, digit and a stop character; a byte of all ones; empty string.
		queue_text("\t-9z", 1'b1);
		push_char(8'hff);
		push_char(CH_NUL);
		push_char(CH_NUL);
		// The number starts in base ten, so the later switch to sixteen must not apply to it.
		queue_text("7", 1'b0);
		wait_idle();
		write_base(BASE_HEX);
		queue_text("f", 1'b1);
		wait_idle();
		write_base(BASE_AUTO);
		queue_text("0xg", 1'b1);
		queue_text("+017", 1'b1);
		wait_idle();
		write_base(BASE_MAX);
		queue_text("Zz", 1'b1);
		wait_idle();
		write_base(BASE_UNIT);
		queue_text("5", 1'b1);
		wait_idle();

		phase_end = chars_queued;
		for (int p = 0; p < 12; p++) begin
			b = (p >= 10) ? 6'($urandom_range(0, 63)) : phase_bases[p];
			write_base(b);
			calm = (p == 3 || p == 7);
			if (b == BASE_DEC) begin
				@(posedge clk);
				hold_go <= 1'b1;
				@(posedge clk);
				hold_go <= 1'b0;
				@(negedge clk);
			end
			phase_end += PHASE_CHARS;
			while (chars_queued < phase_end) begin
				queue_number(b);
			end
			wait_idle();
		end
		calm = 1'b0;

		// A long run of leading white space ahead of a signed number.
		write_base(BASE_DEC);
		repeat (LONG_SPACES) push_char(space_char());
		push_char(CH_MINUS);
		repeat (12) push_char(digit_char(9));
		push_char(CH_NUL);
		wait_idle();

		if (expected_numbers.size() != 0) begin
			report_mismatch($sformatf("%0d results never arrived", expected_numbers.size()));
		end
		$display("Run covered %0d characters and %0d parsed numbers over %0d base settings,",
			chars_accepted, numbers_checked, bases_used);
		$display("with a %0d-cycle output stall and a long run of leading white space.",
			HOLD_CYCLES);
		if (mismatch_count == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
design/tip_pkg.sv
design/tip_step.sv
design/text_to_integer_parser_core.sv
verif/tb_text_to_integer_parser_core.sv
